FILE: rtl/ldts_pkg.sv
package ldts_pkg;

  localparam int STATE_W = 6;
  localparam int TYPE_W  = 3;
  localparam int EVENT_W = 2;
  localparam int LABEL_W = 8;
  localparam int START_W = 8;
  localparam int SIZE_W  = 9;

  localparam logic [1:0] OP_BLOCK_WR = 2'd0;
  localparam logic [1:0] OP_LABEL_WR = 2'd1;
  localparam logic [1:0] OP_STEP     = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [STATE_W-1:0] state_id;
    logic [TYPE_W-1:0]  scatter_type;
    logic [EVENT_W-1:0] scatter_event;
    logic [LABEL_W-1:0] label_index;
    logic               allowed;
    logic               has_empty;
    logic [STATE_W-1:0] empty_next;
    logic [START_W-1:0] block_start;
    logic [SIZE_W-1:0]  block_size;
    logic [STATE_W-1:0] label_next;
  } item_t;

  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic               matched;
  } result_t;

  typedef struct packed {
    logic               allowed;
    logic               has_empty;
    logic [STATE_W-1:0] empty_next;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
  } blk_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_REDUCE,
    ST_SEARCH,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic clear;
    logic accept_ok;
    logic lookup;
    logic reduce;
    logic search;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic step_accept;
    logic need_search;
    logic ptr_reduced;
    logic search_done;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: rtl/labeled_dfa_transition_step.sv
// a step reads its block entry in LOOKUP; if a label search is needed, REDUCE wraps the
// start pointer into the table and SEARCH scans the block, stopping at the first match;
// FINISH registers the result; throughput: one label entry per cycle in SEARCH, table
// writes do not stall the input, a step holds off the next transaction until its result
// is registered; reset: after rst all MAX_STATES*NUM_TYPES*NUM_EVENTS block entries (960
// by default) are swept clear, one entry per cycle, with item_ready low
module labeled_dfa_transition_step import ldts_pkg::*; #(
  parameter int MAX_STATES  = 64,
  parameter int NUM_TYPES   = 5,
  parameter int NUM_EVENTS  = 3,
  parameter int LABEL_DEPTH = 256,
  parameter int LABEL_BITS  = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign item_ready = cmd.accept_ok;

  ldts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  ldts_datapath #(
    .MAX_STATES  (MAX_STATES),
    .NUM_TYPES   (NUM_TYPES),
    .NUM_EVENTS  (NUM_EVENTS),
    .LABEL_DEPTH (LABEL_DEPTH),
    .LABEL_BITS  (LABEL_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

FILE: rtl/ldts_ctrl.sv
module ldts_ctrl import ldts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.accept_ok = 1'b1;
        if (status.step_accept) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = status.need_search ? ST_REDUCE : ST_FINISH;
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        if (status.ptr_reduced) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.search_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/ldts_datapath.sv
module ldts_datapath import ldts_pkg::*; #(
  parameter int MAX_STATES  = 64,
  parameter int NUM_TYPES   = 5,
  parameter int NUM_EVENTS  = 3,
  parameter int LABEL_DEPTH = 256,
  parameter int LABEL_BITS  = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  item_t        item,
  input  logic         item_valid,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  output result_t      result,
  output logic         result_valid,
  input  logic         result_ready
);

  localparam int BLOCK_DEPTH = MAX_STATES * NUM_TYPES * NUM_EVENTS;
  localparam int BA_W  = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int LA_W  = $clog2(LABEL_DEPTH);
  localparam int PTR_W = (LA_W > START_W) ? LA_W : START_W;
  localparam int CNT_W = $clog2(LABEL_DEPTH + 1);
  localparam int LE_W  = LABEL_BITS + STATE_W;

  // block table, cleared by a sweep after reset
  blk_entry_t blk_mem [BLOCK_DEPTH];
  blk_entry_t blk_rdata;
  blk_entry_t blk_wdata;
  logic       blk_we;
  logic [BA_W-1:0] blk_waddr;
  logic [BA_W-1:0] item_addr;
  logic [BA_W-1:0] clr_addr;

  // label table: {label, next}
  logic [LE_W-1:0] lbl_mem [LABEL_DEPTH];
  logic [LE_W-1:0] lbl_rdata;
  logic            lbl_we;
  logic [LA_W-1:0] lbl_waddr;

  logic                  accepting;
  logic                  in_range;
  logic [LABEL_BITS-1:0] item_label;

  logic [STATE_W-1:0]    tok_state;
  logic [LABEL_BITS-1:0] tok_label;
  logic                  tok_in_range;

  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] ptr_inc;
  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic             lbl_hit;
  logic             entry_ok;
  result_t          res;
  result_t          fallback;

  assign accepting  = item_valid && cmd.accept_ok;
  assign item_label = LABEL_BITS'(item.label_index);

  assign in_range = (int'(item.state_id) < MAX_STATES) &&
                    (int'(item.scatter_type) < NUM_TYPES) &&
                    (int'(item.scatter_event) < NUM_EVENTS);

  always_comb begin
    if (in_range) begin
      item_addr = BA_W'((int'(item.scatter_event) * NUM_TYPES + int'(item.scatter_type))
                        * MAX_STATES + int'(item.state_id));
    end else begin
      item_addr = '0;
    end
  end

  assign blk_we    = cmd.clear || (accepting && item.opcode == OP_BLOCK_WR && in_range);
  assign blk_waddr = cmd.clear ? clr_addr : item_addr;

  always_comb begin
    if (cmd.clear) begin
      blk_wdata = '0;
    end else begin
      blk_wdata.allowed    = item.allowed;
      blk_wdata.has_empty  = item.has_empty;
      blk_wdata.empty_next = item.empty_next;
      blk_wdata.start      = item.block_start;
      blk_wdata.size       = item.block_size;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_waddr] <= blk_wdata;
    blk_rdata <= blk_mem[item_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign lbl_we    = accepting && item.opcode == OP_LABEL_WR &&
                     int'(item.block_start) < LABEL_DEPTH;
  assign lbl_waddr = LA_W'(item.block_start);

  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[lbl_waddr] <= {item_label, item.label_next};
    lbl_rdata <= lbl_mem[ptr[LA_W-1:0]];
  end

  // token latch on step accept
  always_ff @(posedge clk) begin
    if (accepting && item.opcode == OP_STEP) begin
      tok_state    <= item.state_id;
      tok_label    <= item_label;
      tok_in_range <= in_range;
    end
  end

  assign entry_ok = tok_in_range && blk_rdata.allowed;

  always_comb begin
    if (entry_ok && blk_rdata.has_empty) begin
      fallback.next_state = blk_rdata.empty_next;
      fallback.matched    = 1'b1;
    end else begin
      fallback.next_state = tok_state;
      fallback.matched    = 1'b0;
    end
  end

  assign ptr_inc = (int'(ptr) + 1 == LABEL_DEPTH) ? '0 : ptr + 1'b1;
  assign lbl_hit = pend && (lbl_rdata[LE_W-1:STATE_W] == tok_label);

  // one label read issued per cycle, compared on the next
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.search) begin
      pend <= (cnt != '0);
    end else begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      res <= fallback;
      ptr <= PTR_W'(blk_rdata.start);
      if (int'(blk_rdata.size) > LABEL_DEPTH) begin
        cnt <= CNT_W'(LABEL_DEPTH);
      end else begin
        cnt <= CNT_W'(blk_rdata.size);
      end
    end else if (cmd.reduce) begin
      if (!status.ptr_reduced) ptr <= ptr - PTR_W'(LABEL_DEPTH);
    end else if (cmd.search) begin
      if (lbl_hit) begin
        res.next_state <= lbl_rdata[STATE_W-1:0];
        res.matched    <= 1'b1;
      end
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        ptr <= ptr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish && status.out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && status.out_free) result <= res;
  end

  always_comb begin
    status.clear_last  = (clr_addr == BA_W'(BLOCK_DEPTH - 1));
    status.step_accept = accepting && item.opcode == OP_STEP;
    status.need_search = entry_ok && tok_label != '0 && blk_rdata.size != '0;
    status.ptr_reduced = int'(ptr) < LABEL_DEPTH;
    status.search_done = lbl_hit || (cnt == '0 && !pend);
    status.out_free    = !result_valid || result_ready;
  end

endmodule

FILE: rtl/ldts_checker.sv
module ldts_checker import ldts_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // a waiting result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // clearing sweep follows reset
  assert property (@(posedge clk)
    rst |=> !result_valid && !item_ready)
    else $error("block active right after reset");

  // a step blocks new transactions and never answers in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.opcode == OP_STEP |=> !item_ready && !$rose(result_valid))
    else $error("step transaction not held off");

  // table writes and ignored codes leave the input ready
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.opcode != OP_STEP |=> item_ready)
    else $error("non-step transaction stalled the input");

endmodule

bind labeled_dfa_transition_step ldts_checker u_ldts_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ldts_pkg::*;

  localparam int MAX_STATES   = 64;
  localparam int NUM_TYPES    = 5;
  localparam int NUM_EVENTS   = 3;
  localparam int LABEL_DEPTH  = 256;
  localparam int BLOCK_DEPTH  = MAX_STATES * NUM_TYPES * NUM_EVENTS;
  localparam int HALF_PERIOD  = 10;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // shadow copy of the transition tables
  blk_entry_t         blk_mem [BLOCK_DEPTH];
  logic [LABEL_W-1:0] lbl_label [LABEL_DEPTH];
  logic [STATE_W-1:0] lbl_next [LABEL_DEPTH];

  dir_row_t    dir_rows [$];
  result_t     transition_q [$];
  int          live_blocks [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;
  bit          long_hold   = 1'b0;

  labeled_dfa_transition_step uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int block_index(input item_t it);
    if (it.state_id >= MAX_STATES || it.scatter_type >= NUM_TYPES ||
        it.scatter_event >= NUM_EVENTS)
      return -1;
    return (int'(it.scatter_event) * NUM_TYPES + int'(it.scatter_type)) * MAX_STATES
           + int'(it.state_id);
  endfunction

  task automatic predict_transition(input item_t it, output bit produces,
                                    output result_t res);
    int idx, n, a, i;
    blk_entry_t b;
    produces = 1'b0;
    res = '0;
    idx = block_index(it);
    case (it.opcode)
      OP_BLOCK_WR: begin
        if (idx >= 0)
          blk_mem[idx] = {it.allowed, it.has_empty, it.empty_next, it.block_start,
                          it.block_size};
      end
      OP_LABEL_WR: begin
        if (int'(it.block_start) < LABEL_DEPTH) begin
          lbl_label[it.block_start] = it.label_index;
          lbl_next[it.block_start] = it.label_next;
        end
      end
      OP_STEP: begin
        produces = 1'b1;
        res.next_state = it.state_id;
        res.matched = 1'b0;
        if (idx >= 0 && blk_mem[idx].allowed) begin
          b = blk_mem[idx];
          if (it.label_index != '0) begin
            n = (b.size > LABEL_DEPTH) ? LABEL_DEPTH : int'(b.size);
            // first match in the block wins, addresses wrap
            for (i = 0; i < n && !res.matched; i++) begin
              a = (int'(b.start) + i) % LABEL_DEPTH;
              if (lbl_label[a] == it.label_index) begin
                res.next_state = lbl_next[a];
                res.matched = 1'b1;
              end
            end
          end
          if (!res.matched && b.has_empty) begin
            res.next_state = b.empty_next;
            res.matched = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic logic [LABEL_W-1:0] draw_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 60) return LABEL_W'($urandom_range(1, 7));
    return LABEL_W'($urandom_range(0, 255));
  endfunction

  function automatic item_t step_item(input int s, t, e, lab);
    item_t it;
    it = '0;
    it.opcode = OP_STEP;
    it.state_id = STATE_W'(s);
    it.scatter_type = TYPE_W'(t);
    it.scatter_event = EVENT_W'(e);
    it.label_index = LABEL_W'(lab);
    return it;
  endfunction

  function automatic item_t blk_item(input int s, t, e, alw, emp, en, st, sz);
    item_t it;
    it = '0;
    it.opcode = OP_BLOCK_WR;
    it.state_id = STATE_W'(s);
    it.scatter_type = TYPE_W'(t);
    it.scatter_event = EVENT_W'(e);
    it.allowed = alw[0];
    it.has_empty = emp[0];
    it.empty_next = STATE_W'(en);
    it.block_start = START_W'(st);
    it.block_size = SIZE_W'(sz);
    return it;
  endfunction

  function automatic item_t lbl_item(input int addr, lab, nxt);
    item_t it;
    it = '0;
    it.opcode = OP_LABEL_WR;
    it.block_start = START_W'(addr);
    it.label_index = LABEL_W'(lab);
    it.label_next = STATE_W'(nxt);
    return it;
  endfunction

  function automatic result_t res_of(input int ns, input bit m);
    result_t r;
    r.next_state = STATE_W'(ns);
    r.matched = m;
    return r;
  endfunction

  function automatic void add_row(input item_t it, input bit typed, input result_t want);
    dir_row_t r;
    r.it = it;
    r.typed = typed;
    r.want = want;
    dir_rows = {dir_rows, r};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // valid stays up across back-to-back transactions
  task automatic push_item(input item_t it, input bit typed = 1'b0,
                           input result_t want = '0);
    int gap;
    bit produces;
    result_t res;
    gap = draw_wait();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_ready !== 1'b1);
    predict_transition(it, produces, res);
    if (produces) transition_q = {transition_q, (typed ? want : res)};
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (transition_q.size() != 0);
  endtask

  initial begin : result_sink
    int stall;
    result_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = long_hold ? HOLD_CYCLES : draw_wait();
      long_hold = 1'b0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (result_valid !== 1'b1);
      if (transition_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result next_state=%0d matched=%0b",
                                  result.next_state, result.matched));
      end else begin
        want = transition_q.pop_front();
        if (result.next_state !== want.next_state)
          report_mismatch($sformatf("next_state %0d, expected %0d",
                                    result.next_state, want.next_state));
        if (result.matched !== want.matched)
          report_mismatch($sformatf("matched %0b, expected %0b",
                                    result.matched, want.matched));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    int k;
    for (k = 0; k < BLOCK_DEPTH; k++) blk_mem[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // fill the whole label table so no search ever reads an unwritten entry
    for (k = 0; k < LABEL_DEPTH; k++) push_item(lbl_item(k, k, k % MAX_STATES));

    // block table still at reset: nothing allowed
    add_row(step_item(0, 0, 0, 0), 1'b1, res_of(0, 0));
    add_row(step_item(63, 4, 2, 255), 1'b1, res_of(63, 0));
    add_row(step_item(21, 7, 3, 5), 1'b1, res_of(21, 0));
    // unused opcode with every bit high
    add_row({$bits(item_t){1'b1}}, 1'b0, '0);
    add_row(blk_item(5, 1, 1, 1, 1, 40, 10, 5), 1'b0, '0);
    add_row(step_item(5, 1, 1, 0), 1'b1, res_of(40, 1));
    add_row(step_item(5, 1, 1, 12), 1'b1, res_of(12, 1));
    add_row(step_item(5, 1, 1, 200), 1'b1, res_of(40, 1));
    // no unlabeled next state
    add_row(blk_item(5, 1, 1, 1, 0, 0, 10, 5), 1'b0, '0);
    add_row(step_item(5, 1, 1, 0), 1'b1, res_of(5, 0));
    add_row(blk_item(5, 1, 1, 0, 1, 40, 10, 5), 1'b0, '0);
    add_row(step_item(5, 1, 1, 12), 1'b1, res_of(5, 0));
    // out-of-range type and event: write dropped, step not allowed
    add_row(blk_item(5, 5, 1, 1, 1, 33, 0, 3), 1'b0, '0);
    add_row(step_item(5, 5, 1, 0), 1'b1, res_of(5, 0));
    add_row(blk_item(9, 2, 3, 1, 1, 33, 0, 3), 1'b0, '0);
    // block wraps past the end of the label table
    add_row(blk_item(63, 4, 2, 1, 1, 63, 250, 10), 1'b0, '0);
    add_row(step_item(63, 4, 2, 3), 1'b1, res_of(3, 1));
    add_row(step_item(63, 4, 2, 249), 1'b1, res_of(63, 1));
    // oversized block, clipped to the table depth
    add_row(blk_item(0, 0, 0, 1, 0, 0, 0, 511), 1'b0, '0);
    add_row(step_item(0, 0, 0, 128), 1'b1, res_of(0, 1));
    add_row(step_item(0, 0, 0, 0), 1'b1, res_of(0, 0));
    // duplicate labels in one block, then an empty block
    add_row(lbl_item(9, 200, 45), 1'b0, '0);
    add_row(lbl_item(10, 200, 46), 1'b0, '0);
    add_row(blk_item(2, 3, 1, 1, 1, 1, 8, 4), 1'b0, '0);
    add_row(step_item(2, 3, 1, 200), 1'b0, '0);
    add_row(blk_item(2, 3, 1, 1, 1, 1, 8, 0), 1'b0, '0);
    add_row(step_item(2, 3, 1, 200), 1'b0, '0);

    foreach (dir_rows[r]) push_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
    drain_results();

    begin : random_phase
      item_t it;
      logic [63:0] noise;
      int issued, pick, idx, span;
      blk_entry_t b;
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
        noise = {$urandom, $urandom};
        it = noise[$bits(item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          it.opcode = OP_UNUSED;
        end else if (pick < 18) begin
          it.opcode = OP_BLOCK_WR;
          if ($urandom_range(0, 9) != 0) begin
            it.scatter_type = TYPE_W'($urandom_range(0, NUM_TYPES - 1));
            it.scatter_event = EVENT_W'($urandom_range(0, NUM_EVENTS - 1));
          end
          it.allowed = ($urandom_range(0, 7) != 0);
          // short blocks keep searches fast, a few span the whole table
          pick = $urandom_range(0, 99);
          if (pick < 80) it.block_size = SIZE_W'($urandom_range(0, 12));
          else if (pick < 92) it.block_size = SIZE_W'($urandom_range(13, 64));
          else if (pick < 97) it.block_size = SIZE_W'($urandom_range(65, 255));
          else it.block_size = SIZE_W'($urandom_range(256, 511));
          idx = block_index(it);
          if (idx >= 0 && it.allowed) live_blocks = {live_blocks, idx};
        end else if (pick < 36) begin
          it.opcode = OP_LABEL_WR;
          if (live_blocks.size() > 0 && $urandom_range(0, 9) < 6) begin
            b = blk_mem[live_blocks[$urandom_range(0, live_blocks.size() - 1)]];
            it.block_start = START_W'(int'(b.start) + int'($urandom_range(0, 15)));
          end
          it.label_index = draw_label();
        end else begin
          it.opcode = OP_STEP;
          if (live_blocks.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            it.state_id = STATE_W'(idx % MAX_STATES);
            it.scatter_type = TYPE_W'((idx / MAX_STATES) % NUM_TYPES);
            it.scatter_event = EVENT_W'(idx / (MAX_STATES * NUM_TYPES));
            b = blk_mem[idx];
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
              it.label_index = '0;
            end else if (pick < 65 && b.size != 0) begin
              // pick a label that sits somewhere in this block
              span = (b.size > LABEL_DEPTH) ? LABEL_DEPTH : int'(b.size);
              it.label_index =
                lbl_label[(int'(b.start) + int'($urandom_range(0, span - 1))) % LABEL_DEPTH];
            end else begin
              it.label_index = draw_label();
            end
          end
        end
        if (it.opcode != OP_UNUSED) issued++;
        if (issued == 50) long_hold = 1'b1;
        no_idle = (issued >= 90 && issued < 130);
        if (issued == 160 && it.opcode != OP_UNUSED) drain_results();
        push_item(it);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
